>>> rtl/mvt_pkg.sv
// shared types and constants of the matrix-vector transform engine
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 4;
    localparam int STORE_SIDE = 4;
    localparam int SIDE_W     = 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    localparam int DIM_DEFAULT         = 4;
    localparam int FRAC_BITS_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

    typedef logic signed [DATA_W-1:0] word_t;

    // one queued request: a load keeps its value in lane 0
    typedef struct packed
    {
        cmd_t                                kind;
        logic [IDX_W-1:0]                    idx;
        logic [STORE_SIDE-1:0][DATA_W-1:0]   vec;
    } item_t;

endpackage

>>> rtl/mvt_front.sv
// front end: accepts and classifies requests and queues them for the back end
`timescale 1ns / 1ps

module mvt_front #(
    parameter int QUEUE_DEPTH = mvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [mvt_pkg::IDX_W-1:0]   entry_index,
    input  logic [mvt_pkg::DATA_W-1:0]  entry_value,
    input  logic [mvt_pkg::DATA_W-1:0]  vec_x,
    input  logic [mvt_pkg::DATA_W-1:0]  vec_y,
    input  logic [mvt_pkg::DATA_W-1:0]  vec_z,
    input  logic [mvt_pkg::DATA_W-1:0]  vec_w,
    output logic                        q_valid,
    input  logic                        q_ready,
    output mvt_pkg::item_t              q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    mvt_pkg::item_t    queue_reg [QUEUE_DEPTH];
    mvt_pkg::item_t    item_in;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    // classify: a load packs its value into lane 0
    always_comb
    begin
        item_in.kind = mvt_pkg::cmd_t'(cmd);
        item_in.idx  = entry_index;
        if (mvt_pkg::cmd_t'(cmd) == mvt_pkg::CMD_LOAD)
        begin
            item_in.vec = {{(3 * mvt_pkg::DATA_W){1'b0}}, entry_value};
        end
        else
        begin
            item_in.vec = {vec_w, vec_z, vec_y, vec_x};
        end
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/mvt_back.sv
// back end: matrix store and three-stage multiply, add and saturate pipeline
`timescale 1ns / 1ps

module mvt_back #(
    parameter int DIM       = mvt_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 q_valid,
    output logic                                                 q_ready,
    input  mvt_pkg::item_t                                       q_item,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [mvt_pkg::STORE_SIDE-1:0][mvt_pkg::DATA_W-1:0]  out_vec
);

    localparam int SIDE = mvt_pkg::STORE_SIDE;

    mvt_pkg::word_t                     matrix_reg [SIDE][SIDE];
    logic signed [mvt_pkg::PROD_W-1:0]  prod_next  [SIDE][SIDE];
    logic signed [mvt_pkg::PROD_W-1:0]  prod_reg   [SIDE][SIDE];
    logic signed [mvt_pkg::PAIR_W-1:0]  pair_reg   [SIDE][2];
    logic signed [mvt_pkg::SUM_W-1:0]   sum_c      [SIDE];
    logic signed [mvt_pkg::SUM_W-1:0]   shift_c    [SIDE];
    logic [SIDE-1:0][mvt_pkg::DATA_W-1:0] sat_c;
    logic [SIDE-1:0][mvt_pkg::DATA_W-1:0] out_reg;
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        pop;
    logic        load_hit;

    // whole pipeline moves together unless the result is held
    assign advance   = !out_valid_reg || out_ready;
    assign q_ready   = advance;
    assign pop       = q_valid && advance;
    assign load_hit  = pop && (q_item.kind == mvt_pkg::CMD_LOAD);
    assign out_valid = out_valid_reg;
    assign out_vec   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SIDE; r++)
            begin
                for (int c = 0; c < SIDE; c++)
                begin
                    matrix_reg[r][c] <= '0;
                end
            end
        end
        else if (load_hit)
        begin
            matrix_reg[q_item.idx[mvt_pkg::IDX_W-1:mvt_pkg::SIDE_W]]
                      [q_item.idx[mvt_pkg::SIDE_W-1:0]] <= $signed(q_item.vec[0]);
        end
    end

    // entries outside the active part give zero products
    always_comb
    begin
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (r < DIM && c < DIM)
                begin
                    prod_next[r][c] = matrix_reg[r][c] * $signed(q_item.vec[c]);
                end
                else
                begin
                    prod_next[r][c] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < SIDE; r++)
        begin
            sum_c[r]   = mvt_pkg::SUM_W'(pair_reg[r][0]) + mvt_pkg::SUM_W'(pair_reg[r][1]);
            shift_c[r] = sum_c[r] >>> FRAC_BITS;
            if ((&shift_c[r][mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1])
                || !(|shift_c[r][mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1]))
            begin
                sat_c[r] = shift_c[r][mvt_pkg::DATA_W-1:0];
            end
            else if (shift_c[r][mvt_pkg::SUM_W-1])
            begin
                sat_c[r] = mvt_pkg::WORD_MIN;
            end
            else
            begin
                sat_c[r] = mvt_pkg::WORD_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop && (q_item.kind == mvt_pkg::CMD_XFORM);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < SIDE; r++)
            begin
                for (int c = 0; c < SIDE; c++)
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
                pair_reg[r][0] <= mvt_pkg::PAIR_W'(prod_reg[r][0])
                                + mvt_pkg::PAIR_W'(prod_reg[r][1]);
                pair_reg[r][1] <= mvt_pkg::PAIR_W'(prod_reg[r][2])
                                + mvt_pkg::PAIR_W'(prod_reg[r][3]);
            end
            out_reg <= sat_c;
        end
    end

endmodule

>>> rtl/matrix_vector_transform_top.sv
// top level of the matrix-vector transform engine
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------------
// input     | in        | in_valid / in_ready  | cmd, entry_index, entry_value, vec_x..w
// result    | out       | out_valid / out_ready| out_x, out_y, out_z, out_w
//
// one request per cycle unless a result is held; each load or transform uses a back-end slot
// a transform result passes through registered stages in order: the products are
// registered as the request leaves the queue, then the pair-sum and add/shift/saturate stages
// reset clears the queue, the pipeline valid flags and all sixteen matrix entries at once
// a held result stalls the whole back end; the queue keeps taking requests until full

module matrix_vector_transform_top #(
    parameter int DIM         = mvt_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS   = mvt_pkg::FRAC_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = mvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic        [mvt_pkg::IDX_W-1:0]   entry_index,
    input  logic signed [mvt_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [mvt_pkg::DATA_W-1:0]  vec_x,
    input  logic signed [mvt_pkg::DATA_W-1:0]  vec_y,
    input  logic signed [mvt_pkg::DATA_W-1:0]  vec_z,
    input  logic signed [mvt_pkg::DATA_W-1:0]  vec_w,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mvt_pkg::DATA_W-1:0]  out_x,
    output logic signed [mvt_pkg::DATA_W-1:0]  out_y,
    output logic signed [mvt_pkg::DATA_W-1:0]  out_z,
    output logic signed [mvt_pkg::DATA_W-1:0]  out_w
);

    // request queue between the two halves
    logic           q_valid;
    logic           q_ready;
    mvt_pkg::item_t q_item;
    logic [mvt_pkg::STORE_SIDE-1:0][mvt_pkg::DATA_W-1:0] out_vec;

    // front: takes requests and classifies loads and transforms
    mvt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .vec_w       (vec_w),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // back: loads update the store in order, transforms run the pipeline
    mvt_back #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_vec   (out_vec)
    );

    // row 0 to row 3 of the product
    assign out_x = $signed(out_vec[0]);
    assign out_y = $signed(out_vec[1]);
    assign out_z = $signed(out_vec[2]);
    assign out_w = $signed(out_vec[3]);

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the matrix-vector transform engine
`timescale 1ns / 1ps

module tb_top;

    // block configuration under test, mirrored in the predictor
    localparam int XF_DIM      = mvt_pkg::DIM_DEFAULT;
    localparam int XF_FRAC     = mvt_pkg::FRAC_BITS_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 50;
    localparam int MAX_LINES   = 40;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    // lane 0 is x, lane 3 is w
    typedef logic [mvt_pkg::STORE_SIDE-1:0][mvt_pkg::DATA_W-1:0] lanes_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        cmd;
    logic [mvt_pkg::IDX_W-1:0]   entry_index;
    mvt_pkg::word_t              entry_value;
    mvt_pkg::word_t              vec_x;
    mvt_pkg::word_t              vec_y;
    mvt_pkg::word_t              vec_z;
    mvt_pkg::word_t              vec_w;
    logic                        out_valid;
    logic                        out_ready;
    mvt_pkg::word_t              out_x;
    mvt_pkg::word_t              out_y;
    mvt_pkg::word_t              out_z;
    mvt_pkg::word_t              out_w;

    // predictor state: copy of the matrix store and the results still owed
    mvt_pkg::word_t      matrix_model [mvt_pkg::STORE_SIDE*mvt_pkg::STORE_SIDE];
    lanes_t              results_q [$];

    int                  error_count;
    bit                  sender_quiet;
    bit                  receiver_quiet;
    int                  hold_cycles;
    string               lane_names [mvt_pkg::STORE_SIDE] =
                             '{"out_x", "out_y", "out_z", "out_w"};

    matrix_vector_transform_top #(
        .DIM       (XF_DIM),
        .FRAC_BITS (XF_FRAC)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .vec_w       (vec_w),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // expected product: exact sum of full products, floor shift, saturate
    function automatic lanes_t transform_vector(input lanes_t v);
        lanes_t                            res;
        logic signed [mvt_pkg::PROD_W-1:0] prod;
        logic signed [mvt_pkg::SUM_W-1:0]  acc;
        logic signed [mvt_pkg::SUM_W-1:0]  shifted;
        res = '0;
        for (int r = 0; r < mvt_pkg::STORE_SIDE; r++)
        begin
            acc = '0;
            if (r < XF_DIM)
            begin
                for (int c = 0; c < XF_DIM; c++)
                begin
                    prod = matrix_model[r*mvt_pkg::STORE_SIDE + c]
                         * mvt_pkg::word_t'(v[c]);
                    acc  = acc + prod;
                end
                shifted = acc >>> XF_FRAC;
                if (shifted > SAT_HI)
                    res[r] = mvt_pkg::WORD_MAX;
                else if (shifted < SAT_LO)
                    res[r] = mvt_pkg::WORD_MIN;
                else
                    res[r] = shifted[mvt_pkg::DATA_W-1:0];
            end
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // operand mix: extremes, small fixed-point values and full-range noise
    function automatic mvt_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return mvt_pkg::WORD_MIN;
            1:       return mvt_pkg::WORD_MAX;
            2:       return '0;
            3:       return mvt_pkg::word_t'(-1);
            4, 5:    return mvt_pkg::word_t'($urandom_range(0, 32'h0008_0000))
                          - mvt_pkg::word_t'(32'h0004_0000);
            6:       return $urandom_range(0, 1) ? mvt_pkg::word_t'(32'h0001_0000)
                                                 : mvt_pkg::word_t'(32'hFFFF_0000);
            default: return mvt_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_LINES)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // offer one request and hold it until taken; called on a rising edge
    task automatic send_request(input mvt_pkg::cmd_t kind,
                                input logic [mvt_pkg::IDX_W-1:0] idx,
                                input mvt_pkg::word_t value, input lanes_t v);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= kind;
        entry_index <= idx;
        entry_value <= value;
        vec_x       <= v[0];
        vec_y       <= v[1];
        vec_z       <= v[2];
        vec_w       <= v[3];
        do
            @(posedge clk);
        while (!in_ready);
        // taken at this edge: update the model in request order
        if (kind == mvt_pkg::CMD_LOAD)
            matrix_model[idx] = value;
        else
            results_q.push_back(transform_vector(v));
    endtask

    // stop offering until every owed result has been seen
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_q.size() != 0);
    endtask

    task automatic send_random_request();
        lanes_t v;
        for (int i = 0; i < mvt_pkg::STORE_SIDE; i++)
            v[i] = pick_word();
        if ($urandom_range(0, 3) == 0)
            send_request(mvt_pkg::CMD_LOAD, mvt_pkg::IDX_W'($urandom), pick_word(), v);
        else
            send_request(mvt_pkg::CMD_XFORM, mvt_pkg::IDX_W'($urandom),
                         mvt_pkg::word_t'($urandom), v);
    endtask

    // a transform straight after reset must see an all-zero matrix
    task automatic test_cleared_store();
        send_request(mvt_pkg::CMD_XFORM, 4'hF, mvt_pkg::WORD_MAX,
                     {mvt_pkg::WORD_MIN, mvt_pkg::WORD_MAX, 32'hFFFF_FFFF, 32'h0001_0000});
    endtask

    // corner products: both saturation limits, exact extremes, floor rounding
    task automatic test_corner_products();
        for (int i = 0; i < mvt_pkg::STORE_SIDE; i++)
            send_request(mvt_pkg::CMD_LOAD, mvt_pkg::IDX_W'(i), mvt_pkg::WORD_MIN,
                         {mvt_pkg::STORE_SIDE{mvt_pkg::WORD_MAX}});
        send_request(mvt_pkg::CMD_LOAD, 4'd5, 32'h0001_0000,
                     {mvt_pkg::STORE_SIDE{mvt_pkg::WORD_MIN}});
        send_request(mvt_pkg::CMD_LOAD, 4'd10, mvt_pkg::word_t'(-1), '0);
        send_request(mvt_pkg::CMD_LOAD, 4'd15, mvt_pkg::WORD_MAX,
                     {mvt_pkg::STORE_SIDE{32'h5A5A_A5A5}});
        send_request(mvt_pkg::CMD_XFORM, '0, '0, {mvt_pkg::STORE_SIDE{mvt_pkg::WORD_MIN}});
        send_request(mvt_pkg::CMD_XFORM, 4'hA, mvt_pkg::word_t'(32'h1234_5678),
                     {mvt_pkg::STORE_SIDE{32'h0000_0001}});
        send_request(mvt_pkg::CMD_XFORM, 4'h3, mvt_pkg::WORD_MIN,
                     {mvt_pkg::STORE_SIDE{mvt_pkg::WORD_MAX}});
        send_request(mvt_pkg::CMD_XFORM, 4'h7, mvt_pkg::WORD_MAX,
                     {32'hFFFF_FFFF, 32'h0000_0001, mvt_pkg::WORD_MIN, mvt_pkg::WORD_MAX});
        // overwrite entries already in use, then the last index
        send_request(mvt_pkg::CMD_LOAD, 4'd0, mvt_pkg::WORD_MAX, '0);
        send_request(mvt_pkg::CMD_LOAD, 4'd15, '0, '0);
        send_request(mvt_pkg::CMD_XFORM, '0, '0, {mvt_pkg::STORE_SIDE{32'hFFFF_FFFF}});
        send_request(mvt_pkg::CMD_XFORM, 4'hF, mvt_pkg::word_t'(-1),
                     {32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_0000, 32'h8000_0001});
    endtask

    // random mix in segments, each with its own idling style
    task automatic test_random_traffic();
        for (int s = 0; s < SEGMENTS; s++)
        begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_random_request();
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // receiver holds off long enough for the queue to fill and stall input
    task automatic test_back_pressure();
        sender_quiet = 1'b1;
        hold_cycles  = HOLD_CYCLES;
        for (int n = 0; n < 24; n++)
            send_random_request();
        sender_quiet = 1'b0;
        wait_for_results();
        for (int n = 0; n < 16; n++)
            send_random_request();
    endtask

    // result side: random ready pattern, plus long holds when asked
    initial
    begin : result_sink
        int gap_left;
        int burst_left;
        gap_left   = 0;
        burst_left = 0;
        out_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (gap_left == 0 && burst_left == 0)
                begin
                    gap_left   = pick_gap(receiver_quiet);
                    burst_left = $urandom_range(1, 12);
                end
                if (gap_left > 0)
                begin
                    out_ready <= 1'b0;
                    gap_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                    burst_left--;
                end
            end
        end
    end

    // each taken result against the oldest owed one, lane by lane
    always @(posedge clk)
    begin : result_check
        lanes_t got;
        lanes_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_w, out_z, out_y, out_x};
            if (results_q.size() == 0)
                report_error($sformatf("unexpected result %h", got));
            else
            begin
                want = results_q.pop_front();
                for (int i = 0; i < mvt_pkg::STORE_SIDE; i++)
                    if (got[i] !== want[i])
                        report_error($sformatf("%s got %0d want %0d", lane_names[i],
                                               $signed(got[i]), $signed(want[i])));
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        error_count    = 0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        hold_cycles    = 0;
        for (int i = 0; i < mvt_pkg::STORE_SIDE*mvt_pkg::STORE_SIDE; i++)
            matrix_model[i] = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= mvt_pkg::CMD_LOAD;
        entry_index <= '0;
        entry_value <= '0;
        vec_x       <= '0;
        vec_y       <= '0;
        vec_z       <= '0;
        vec_w       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_store();
        test_corner_products();
        test_random_traffic();
        test_back_pressure();

        // drain, then wait for anything stray
        wait_for_results();
        repeat (10) @(posedge clk);
        if (results_q.size() != 0)
            report_error($sformatf("%0d results never arrived", results_q.size()));

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
